// ===== sv/dphh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_pkg: shared types and constants of the pulse-height histogram
// Field widths of the ports, parameter defaults and the result record.
// ----------------------------------------------------------------------------
package dphh_pkg;

    localparam int SAMPLE_W       = 10;  // converter sample width
    localparam int DEC_W          = 16;  // decimation register / skip counter
    localparam int OUT_BIN_W      = 10;  // bin_index port width
    localparam int OUT_COUNT_W    = 24;  // bin_count port width
    localparam int BIN_BITS_DEF   = 10;
    localparam int COUNT_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 2;   // depth of both decoupling queues

    typedef struct packed {
        logic                   taken;
        logic [OUT_BIN_W-1:0]   bin;
        logic [OUT_COUNT_W-1:0] count;
    } result_t;

endpackage

// ===== sv/dphh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module dphh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dphh_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_fifo: small register queue
// Power-of-two depth, first-word fall-through, full/empty flags.
// ----------------------------------------------------------------------------
module dphh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/dphh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_front: sample intake and decimation
// Holds the decimation register and the skip counter, tags each sample as
// taken or skipped and forwards {taken, bin} to the work queue.
// ----------------------------------------------------------------------------
module dphh_front
    import dphh_pkg::*;
#(
    parameter int BIN_BITS = BIN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [DEC_W-1:0]    cfg_wr_data,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic                full,
    input  logic                clearing,
    input  logic                work_full,
    output logic                work_push,
    output logic [BIN_BITS:0]   work_data
);

    logic [DEC_W-1:0] dec_reg;
    logic [DEC_W-1:0] skip_reg, skip_next;
    logic             accept;
    logic             taken;

    assign full      = work_full | clearing;
    assign accept    = push & ~full;
    assign taken     = (skip_reg == dec_reg);
    assign work_push = accept;
    assign work_data = {taken, adc_sample[SAMPLE_W-1 -: BIN_BITS]};

    always_comb
    begin
        skip_next = skip_reg;
        if (accept)
        begin
            skip_next = taken ? '0 : skip_reg + 1'b1;  // wraps past the register value
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg  <= '0;
            skip_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dec_reg <= cfg_wr_data;
            end
            skip_reg <= skip_next;
        end
    end

endmodule

// ===== sv/dphh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_back: histogram update engine
// Read-modify-write of the bin memory with last-write forwarding, plus the
// clearing sweep after reset. Produces one result record per item.
// ----------------------------------------------------------------------------
module dphh_back
    import dphh_pkg::*;
#(
    parameter int BIN_BITS   = BIN_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_empty,
    input  logic [BIN_BITS:0] work_data,
    output logic              work_pop,
    input  logic              res_full,
    output logic              res_push,
    output result_t           res_data,
    output logic              clearing
);

    logic                  clr_reg;
    logic [BIN_BITS-1:0]   clr_addr_reg;

    // update stage
    logic                  b_valid_reg, b_valid_next;
    logic                  b_taken_reg;
    logic [BIN_BITS-1:0]   b_bin_reg;

    // most recent memory write, for forwarding
    logic                  lw_valid_reg;
    logic [BIN_BITS-1:0]   lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;

    logic                  advance;
    logic                  b_fire;
    logic                  upd_we;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] new_count;
    logic                  ram_we;
    logic [BIN_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign clearing = clr_reg;
    assign advance  = ~b_valid_reg | ~res_full;
    assign work_pop = ~work_empty & advance & ~clr_reg;
    assign b_fire   = b_valid_reg & ~res_full;
    assign upd_we   = b_fire & b_taken_reg;

    assign cur_count = (lw_valid_reg && (lw_addr_reg == b_bin_reg)) ? lw_data_reg : rd_count;
    assign new_count = cur_count + 1'b1;

    assign ram_we    = clr_reg | upd_we;
    assign ram_waddr = clr_reg ? clr_addr_reg : b_bin_reg;
    assign ram_wdata = clr_reg ? '0 : new_count;

    dphh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (1 << BIN_BITS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (work_pop),
        .raddr (work_data[BIN_BITS-1:0]),
        .rdata (rd_count)
    );

    always_comb
    begin
        res_push = b_fire;
        res_data = '0;
        if (b_taken_reg)
        begin
            res_data.taken = 1'b1;
            res_data.bin   = OUT_BIN_W'(b_bin_reg);
            res_data.count = OUT_COUNT_W'(new_count);
        end
    end

    always_comb
    begin
        priority if (work_pop)
        begin
            b_valid_next = 1'b1;
        end
        else if (advance)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clr_reg <= 1'b0;
                end
            end
            b_valid_reg <= b_valid_next;
            if (clr_reg)
            begin
                lw_valid_reg <= 1'b0;
            end
            else if (upd_we)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            b_taken_reg <= work_data[BIN_BITS];
            b_bin_reg   <= work_data[BIN_BITS-1:0];
        end
        if (upd_we)
        begin
            lw_addr_reg <= b_bin_reg;
            lw_data_reg <= new_count;
        end
    end

endmodule

// ===== sv/decimated_pulse_height_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimated_pulse_height_histogram: multichannel analyzer with decimation
// Keeps a histogram of converter samples, taking every (N+1)th sample.
// ----------------------------------------------------------------------------
// Each converter sample pushed in yields exactly one result. A skip counter
// is compared with the decimation register: on a match the sample is
// taken, its top BIN_BITS bits select a bin, the bin count (COUNT_BITS
// wide, wrapping) is incremented and the result carries sample_taken = 1,
// the bin and the new count; otherwise the counter advances and the result
// is all zero. After reset the block sweeps the bin memory to zero, one bin
// per cycle; full stays high meanwhile, while configuration writes are
// taken at any time. Sustained rate is one transfer per clock on both sides
// while results are popped: the bin memory is read as an item leaves the
// work queue and the last write is forwarded, so hits on the same bin back
// to back do not stall. A result passes the work queue write, the memory
// read and the result queue write before it shows on the output. Front and
// back are decoupled by a two-entry queue, and a two-entry result queue lets
// new samples come in while a result waits to be popped.
// ----------------------------------------------------------------------------
module decimated_pulse_height_histogram
    import dphh_pkg::*;
#(
    parameter int BIN_BITS   = BIN_BITS_DEF,    // 8..10
    parameter int COUNT_BITS = COUNT_BITS_DEF   // 8..24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // decimation register
    input  logic                   cfg_wr_en,
    input  logic [DEC_W-1:0]       cfg_wr_data,
    // sample input
    input  logic                   push,
    input  logic [SAMPLE_W-1:0]    adc_sample,
    output logic                   full,
    // results
    input  logic                   pop,
    output logic                   empty,
    output logic                   sample_taken,
    output logic [OUT_BIN_W-1:0]   bin_index,
    output logic [OUT_COUNT_W-1:0] bin_count
);

    localparam int WORK_W = BIN_BITS + 1;

    logic              clearing;
    logic              work_push;
    logic [WORK_W-1:0] work_wdata;
    logic              work_full;
    logic              work_pop;
    logic [WORK_W-1:0] work_rdata;
    logic              work_empty;
    logic              res_push;
    result_t           res_wdata;
    logic              res_full;
    result_t           res_rdata;

    // intake: decimation and bin extraction
    dphh_front #(
        .BIN_BITS (BIN_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .adc_sample  (adc_sample),
        .full        (full),
        .clearing    (clearing),
        .work_full   (work_full),
        .work_push   (work_push),
        .work_data   (work_wdata)
    );

    // classified items waiting for the histogram engine
    dphh_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_wdata),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_rdata),
        .empty (work_empty)
    );

    // bin memory read-modify-write
    dphh_back #(
        .BIN_BITS   (BIN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_empty (work_empty),
        .work_data  (work_rdata),
        .work_pop   (work_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_wdata),
        .clearing   (clearing)
    );

    // finished results; head entry drives the output ports
    dphh_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign sample_taken = res_rdata.taken;
    assign bin_index    = res_rdata.bin;
    assign bin_count    = res_rdata.count;

endmodule

// ===== tb/sv/dphh_histogram_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_histogram_check: result checker for the pulse-height histogram
// Tracks the skip counter and bin counts, queues one expected result per
// input transfer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module dphh_histogram_check
    import dphh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [DEC_W-1:0]       cfg_wr_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [SAMPLE_W-1:0]    adc_sample,
    input  logic                   pop,
    input  logic                   empty,
    input  logic                   sample_taken,
    input  logic [OUT_BIN_W-1:0]   bin_index,
    input  logic [OUT_COUNT_W-1:0] bin_count,
    output int                     mismatches,
    output int                     outstanding
);

    localparam int BIN_SHIFT   = SAMPLE_W - BIN_BITS_DEF;
    localparam int NUM_BINS    = 1 << BIN_BITS_DEF;

    logic [DEC_W-1:0]          decimation;
    logic [DEC_W-1:0]          skip_count;
    logic [COUNT_BITS_DEF-1:0] bin_tally [NUM_BINS];
    result_t                   expected_results [$];
    int                        fail_tally = 0;
    int                        waiting    = 0;

    assign mismatches  = fail_tally;
    assign outstanding = waiting;

    // one converter sample through the decimator and, if taken, the histogram
    function automatic result_t histogram_update(input logic [SAMPLE_W-1:0] value);
        result_t                 res;
        logic [BIN_BITS_DEF-1:0] bin;
        res = '0;
        if (skip_count == decimation)
        begin
            bin            = BIN_BITS_DEF'(value >> BIN_SHIFT);
            bin_tally[bin] = bin_tally[bin] + 1'b1;   // wraps at 2^COUNT_BITS
            skip_count     = '0;
            res.taken      = 1'b1;
            res.bin        = OUT_BIN_W'(bin);
            res.count      = OUT_COUNT_W'(bin_tally[bin]);
        end
        else
        begin
            skip_count = skip_count + 1'b1;          // wraps at 2^16
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        fail_tally++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        if (!rst_n)
        begin
            decimation = '0;
            skip_count = '0;
            foreach (bin_tally[i])
                bin_tally[i] = '0;
            expected_results.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                decimation = cfg_wr_data;
            if (push && !full)
                expected_results.push_back(histogram_update(adc_sample));
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("unexpected transfer (bin_count)", 0, bin_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (sample_taken !== want.taken)
                        flag_mismatch("sample_taken", want.taken, sample_taken);
                    if (bin_index !== want.bin)
                        flag_mismatch("bin_index", want.bin, bin_index);
                    if (bin_count !== want.count)
                        flag_mismatch("bin_count", want.count, bin_count);
                end
            end
            waiting <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/decimated_pulse_height_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimated_pulse_height_histogram_tb: testbench of the pulse-height histogram
// Directed corner samples, random phases with random flow control on both
// sides and one long result hold-off, then short runs at the widest setting
// and with a skip counter left above a lowered setting. Checking is done by
// dphh_histogram_check.
// ----------------------------------------------------------------------------
module decimated_pulse_height_histogram_tb;
    import dphh_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 8;          // extra wait after the last result is popped
    localparam int HOLD_OFF_CYCLES = 80;        // long receiver stall, fills both queues
    localparam int LONG_RUN_ITEMS = 16;         // samples per closing run, all of them skipped
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 130;
    localparam int IDLE_PCT       = 21;
    localparam int TIMEOUT_NS     = 500_000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [DEC_W-1:0]       cfg_wr_data = '0;
    logic                   push        = 1'b0;
    logic [SAMPLE_W-1:0]    adc_sample  = '0;
    logic                   pop         = 1'b0;
    logic                   full;
    logic                   empty;
    logic                   sample_taken;
    logic [OUT_BIN_W-1:0]   bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;

    int                     mismatches;
    int                     outstanding;

    // flow-control knobs shared by the sender and receiver processes
    bit                     idle_on          = 1'b1;
    bit                     hold_off_request = 1'b0;

    // hot samples per random phase: repeated bins build up counts and hit
    // the read-modify-write forwarding path back to back
    logic [SAMPLE_W-1:0]    hot_values [4];
    logic [SAMPLE_W-1:0]    corner_values [26];

    decimated_pulse_height_histogram #(
        .BIN_BITS   (BIN_BITS_DEF),
        .COUNT_BITS (COUNT_BITS_DEF)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .adc_sample   (adc_sample),
        .full         (full),
        .pop          (pop),
        .empty        (empty),
        .sample_taken (sample_taken),
        .bin_index    (bin_index),
        .bin_count    (bin_count)
    );

    dphh_histogram_check hist_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .full         (full),
        .adc_sample   (adc_sample),
        .pop          (pop),
        .empty        (empty),
        .sample_taken (sample_taken),
        .bin_index    (bin_index),
        .bin_count    (bin_count),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // One sample transfer. Entered right after a rising edge; returns right
    // after the edge that took the sample. Random idle cycles go in front,
    // and push stays high from one sample to the next when there is no gap.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        adc_sample <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Register write; only called while nothing is in flight.
    task automatic write_decimation(input logic [DEC_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has been popped.
    // The first edge lets the checker count the last sample transfer.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mix of rail values, hot bins and uniform samples.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? '1 : '0;
            1, 2, 3: return hot_values[$urandom_range(3)];
            default: return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
        endcase
    endfunction

    // Receiver: pops at random, or every cycle when idling is off. On request
    // it holds pop low for a long stretch while the sender keeps offering,
    // so the block backs up and raises full.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            pop <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [DEC_W-1:0] setting;

        // rails, single-bit and alternating patterns, same bin back to back
        corner_values = '{10'd0,   10'd1023, 10'd512, 10'd511, 10'd341,
                          10'd682, 10'd1023, 10'd1023, 10'd1023, 10'd0,
                          10'd1,   10'd0,    10'd1,   10'd768,
                          10'd5,   10'd5,    10'd5,   10'd5,   10'd1023, 10'd1023,
                          10'd640, 10'd640,  10'd640, 10'd640, 10'd640, 10'd640};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Setting 0 takes every sample; 1 and 2 show skipped
        // samples with zeroed bin and count, each run ending on a take.
        // Full stays high during the post-reset clearing sweep, so the first
        // transfer waits on it.
        write_decimation('0);
        for (int i = 0; i < 14; i++)
            send_sample(corner_values[i]);
        settle();
        write_decimation(DEC_W'(1));
        for (int i = 14; i < 20; i++)
            send_sample(corner_values[i]);
        settle();
        write_decimation(DEC_W'(2));
        for (int i = 20; i < 26; i++)
            send_sample(corner_values[i]);
        settle();

        // Random phases. Phase 3 runs both sides without idling; phase 5
        // carries the long receiver hold-off.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       setting = '0;
                1:       setting = DEC_W'(1);
                default: setting = DEC_W'($urandom_range(6));
            endcase
            // below the running skip count nothing would be taken until the
            // counter wraps, so keep the setting at or above it
            if (setting < hist_check.skip_count)
                setting = hist_check.skip_count;
            write_decimation(setting);
            foreach (hot_values[i])
                hot_values[i] = SAMPLE_W'($urandom_range(1023));
            idle_on = (phase != 3);
            if (phase == 5)
                hold_off_request = 1'b1;
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            settle();
        end

        // Widest setting: every sample of the run is skipped.
        write_decimation('1);
        repeat (LONG_RUN_ITEMS) send_sample(SAMPLE_W'($urandom_range(1023)));
        settle();

        // Lowered below the running skip count: the counter keeps counting
        // up past the setting and no sample is taken.
        write_decimation(DEC_W'(8));
        repeat (LONG_RUN_ITEMS) send_sample(SAMPLE_W'($urandom_range(1023)));
        settle();

        if (mismatches == 0)
            $display("PASS decimated_pulse_height_histogram");
        else
            $display("FAIL decimated_pulse_height_histogram");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL decimated_pulse_height_histogram");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dphh_pkg.sv
sv/dphh_ram.sv
sv/dphh_fifo.sv
sv/dphh_front.sv
sv/dphh_back.sv
sv/decimated_pulse_height_histogram.sv
tb/sv/dphh_histogram_check.sv
tb/sv/decimated_pulse_height_histogram_tb.sv
